// ===== rtl/positional_list_store_macros.svh =====
// Assertion macros shared by the list store RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is low.
`define PLS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("list store check failed");

// Next-cycle implication, disabled while reset is low.
`define PLS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("list store check failed");

`else

`define PLS_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define PLS_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pls_pkg.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// pls_pkg: shared types and constants of the positional list store
// Field widths, request and status codes, and the command that the control
// unit broadcasts along the row of storage cells.
//------------------------------------------------------------------------------
package pls_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 5;
	localparam int LEN_W    = 5;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_WRITE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Command broadcast to every cell; at most one of ins/del/wr/rd is set
	typedef struct packed {
		logic             ins;
		logic             del;
		logic             wr;
		logic             rd;
		logic [IDX_W-1:0] pos;
		word_t            value;
	} cell_cmd_t;

endpackage

// ===== rtl/pls_if.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// pls_if: request and response channels of the positional list store
// Valid/ready channels; a transaction completes when valid and ready are high.
//------------------------------------------------------------------------------
interface pls_req_if;
	logic                          valid;
	logic                          ready;
	pls_pkg::op_t                  op;
	logic [pls_pkg::POS_W-1:0]     position;
	pls_pkg::word_t                value;

	modport source (output valid, output op, output position, output value, input ready);
	modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface pls_rsp_if;
	logic                          valid;
	logic                          ready;
	pls_pkg::word_t                read_value;
	logic [pls_pkg::LEN_W-1:0]     length;
	pls_pkg::status_t              status;

	modport source (output valid, output read_value, output length, output status,
		input ready);
	modport sink   (input valid, input read_value, input length, input status,
		output ready);
endinterface

// ===== rtl/positional_list_store.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// positional_list_store: bounded list of signed 32-bit words by position
// Each request transaction (insert before a position, delete, read or write
// at a position) yields exactly one result transaction carrying the read
// word (zero unless a successful read), the length after the request and a
// status of ok, full or out of range. The list lives in a row of CAPACITY
// cells; every cell shifts, loads or holds in the same cycle, so one request
// is taken per cycle while the result register is free or draining. The
// result is registered and appears the cycle after acceptance; a new request
// is taken while a result waits, as long as that result is taken in the same
// cycle. The cell row shifts in parallel together with the length update.
//------------------------------------------------------------------------------
module positional_list_store (
	input  logic       clk,
	input  logic       arst_n,
	pls_req_if.sink    req,
	pls_rsp_if.source  rsp
);

	pls_pkg::cell_cmd_t cmd;
	pls_pkg::word_t     cell_data [pls_pkg::CAPACITY];
	pls_pkg::word_t     rd_chain  [pls_pkg::CAPACITY+1];

	pls_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.rd_data (rd_chain[0]),
		.cmd     (cmd)
	);

	// Terminate the read chain past the last cell
	assign rd_chain[pls_pkg::CAPACITY] = '0;

	// Build the row of cells, each wired to its neighbors
	for (genvar i = 0; i < pls_pkg::CAPACITY; i++) begin : g_cell
		pls_pkg::word_t left_w;
		pls_pkg::word_t right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_data[i-1];
		end

		if (i == pls_pkg::CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_data[i+1];
		end

		pls_cell u_cell (
			.clk        (clk),
			.idx        (pls_pkg::IDX_W'(i)),
			.cmd        (cmd),
			.left_data  (left_w),
			.right_data (right_w),
			.rd_in      (rd_chain[i+1]),
			.data       (cell_data[i]),
			.rd_out     (rd_chain[i])
		);
	end

endmodule

// ===== rtl/pls_cell.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// pls_cell: one storage slot of the list
// Holds one entry; shifts from its left neighbor on insert, from its right
// neighbor on delete, loads the broadcast value at its own position, and
// merges its entry into the read chain when selected.
//------------------------------------------------------------------------------
module pls_cell (
	input  logic                        clk,
	input  logic [pls_pkg::IDX_W-1:0]   idx,
	input  pls_pkg::cell_cmd_t          cmd,
	input  pls_pkg::word_t              left_data,
	input  pls_pkg::word_t              right_data,
	input  pls_pkg::word_t              rd_in,
	output pls_pkg::word_t              data,
	output pls_pkg::word_t              rd_out
);

	pls_pkg::word_t data_q;
	pls_pkg::word_t data_d;
	logic           at_pos;
	logic           after_pos;

	assign at_pos    = (idx == cmd.pos);
	assign after_pos = (idx > cmd.pos);

	// Pick the next entry: open a gap, close a gap, or overwrite
	always_comb begin
		data_d = data_q;
		priority if (cmd.ins) begin
			if (at_pos) begin
				data_d = cmd.value;
			end else if (after_pos) begin
				data_d = left_data;
			end
		end else if (cmd.del) begin
			if (at_pos || after_pos) begin
				data_d = right_data;
			end
		end else if (cmd.wr) begin
			if (at_pos) begin
				data_d = cmd.value;
			end
		end
	end

	// Hold the entry
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	// Merge into the read chain when this slot is addressed
	assign rd_out = rd_in | ((cmd.rd && at_pos) ? data_q : pls_pkg::word_t'(0));
	assign data   = data_q;

endmodule

// ===== rtl/pls_ctrl.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// pls_ctrl: request checking, length counter and result register
// Validates each request against the current length, issues the cell command,
// updates the length and registers the result transaction.
//------------------------------------------------------------------------------
`include "positional_list_store_macros.svh"

module pls_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	pls_req_if.sink               req,
	pls_rsp_if.source             rsp,
	input  pls_pkg::word_t        rd_data,
	output pls_pkg::cell_cmd_t    cmd
);

	logic [pls_pkg::CNT_W-1:0] count_q;
	logic [pls_pkg::CNT_W-1:0] count_d;
	logic                      out_valid_q;
	pls_pkg::word_t            read_value_q;
	logic [pls_pkg::LEN_W-1:0] length_q;
	pls_pkg::status_t          status_q;
	pls_pkg::status_t          st;
	logic [pls_pkg::CMP_W-1:0] pos_ext;
	logic [pls_pkg::CMP_W-1:0] cnt_ext;
	logic                      fire;
	logic                      ok;

	// Take a new transaction whenever the result register is free or draining
	assign req.ready = !out_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	assign pos_ext = pls_pkg::CMP_W'(req.position);
	assign cnt_ext = pls_pkg::CMP_W'(count_q);

	// Check the request: full before range on insert
	always_comb begin
		st = pls_pkg::ST_OK;
		unique case (req.op)
			pls_pkg::OP_INSERT: begin
				if (count_q == pls_pkg::CNT_W'(pls_pkg::CAPACITY)) begin
					st = pls_pkg::ST_FULL;
				end else if (pos_ext > cnt_ext) begin
					st = pls_pkg::ST_RANGE;
				end
			end
			pls_pkg::OP_DELETE, pls_pkg::OP_READ, pls_pkg::OP_WRITE: begin
				if (pos_ext >= cnt_ext) begin
					st = pls_pkg::ST_RANGE;
				end
			end
			default: st = pls_pkg::ST_RANGE;
		endcase
	end

	assign ok = fire && (st == pls_pkg::ST_OK);

	// Broadcast the command to the cell row
	always_comb begin
		cmd.ins   = ok && (req.op == pls_pkg::OP_INSERT);
		cmd.del   = ok && (req.op == pls_pkg::OP_DELETE);
		cmd.wr    = ok && (req.op == pls_pkg::OP_WRITE);
		cmd.rd    = ok && (req.op == pls_pkg::OP_READ);
		cmd.pos   = pls_pkg::IDX_W'(req.position);
		cmd.value = req.value;
	end

	// Advance the length
	always_comb begin
		count_d = count_q;
		if (cmd.ins) begin
			count_d = count_q + 1'b1;
		end else if (cmd.del) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			read_value_q <= rd_data;
			length_q     <= pls_pkg::LEN_W'(count_d);
			status_q     <= st;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.length     = length_q;
	assign rsp.status     = status_q;

	`PLS_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= pls_pkg::CNT_W'(pls_pkg::CAPACITY))
	`PLS_ASSERT_NEXT(a_ins_grows, clk, arst_n, cmd.ins, count_q == $past(count_q) + 1'b1)
	`PLS_ASSERT_NEXT(a_del_shrinks, clk, arst_n, cmd.del, count_q == $past(count_q) - 1'b1)
	`PLS_ASSERT_NOW(a_full_only_at_cap, clk, arst_n, fire && (st == pls_pkg::ST_FULL), count_q == pls_pkg::CNT_W'(pls_pkg::CAPACITY))
	`PLS_ASSERT_NOW(a_rd_quiet, clk, arst_n, !cmd.rd, rd_data == pls_pkg::word_t'(0))

endmodule
